// ----- rtl/core/dpf_pkg.sv -----
// Package for the four-lane binary64 dot product: shared constants, types
// and the wide-word helpers used by the FMA.
// No dependencies.
package dpf_pkg;

    localparam int LANES      = 4;
    localparam int TAILS      = LANES - 1;
    localparam int FMA_STAGES = 13;

    localparam logic [63:0] F64_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] F64_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] F64_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] F64_POS_INF  = 64'h7FF0_0000_0000_0000;

    typedef logic signed [13:0] exp_t;

    typedef enum logic [1:0] {
        MRG_IDLE,
        MRG_BUSY,
        MRG_HOLD
    } merge_state_t;

    typedef struct packed {
        logic [LANES-1:0][63:0] lane_sum;
        logic [TAILS-1:0][63:0] tail_a;
        logic [TAILS-1:0][63:0] tail_b;
        logic [1:0]             tail_cnt;
    } merge_req_t;

    // leading zeros of a 128-bit word, 128 when zero
    function automatic logic [7:0] lzc128(input logic [127:0] x);
        logic [7:0] n;
        logic       found;
        n     = 8'd128;
        found = 1'b0;
        for (int i = 127; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 8'(127 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // right shift by 0..128, lost bits folded into bit 0
    function automatic logic [127:0] sticky_shr(input logic [127:0] x, input logic [7:0] n);
        logic [127:0] r;
        logic         lost;
        r    = x >> n;
        lost = |(x & ~({128{1'b1}} << n));
        return {r[127:1], r[0] | lost};
    endfunction

endpackage

// ----- rtl/core/dpf_fma.sv -----
// Pipelined binary64 fused multiply-add, a*b + c with one round to nearest
// even; thirteen stages, one 27x27 multiplier per multiply stage. Uses dpf_pkg.
module dpf_fma (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [63:0] in_a,
    input  logic [63:0] in_b,
    input  logic [63:0] in_c,
    output logic        out_valid,
    output logic [63:0] out_res
);
    import dpf_pkg::*;

    typedef struct packed {
        logic        spec;
        logic [63:0] specv;
        logic        sp;
        logic        sc;
        logic        czero;
        exp_t        ep;
        exp_t        ec;
        logic [52:0] sigc;
    } fma_side_t;

    function automatic logic [52:0] sig_of(input logic [63:0] x);
        return (x[62:52] != 11'd0) ? {1'b1, x[51:0]} : {1'b0, x[51:0]};
    endfunction

    function automatic exp_t exp_of(input logic [63:0] x);
        logic [10:0] be;
        be = (x[62:52] != 11'd0) ? x[62:52] : 11'd1;
        return exp_t'({3'b0, be}) - 14'sd1075;
    endfunction

    logic [FMA_STAGES-1:0] vld_reg;
    fma_side_t             side_reg [FMA_STAGES];
    fma_side_t             side_next;

    logic [52:0]  sa0_reg, sb0_reg, sa1_reg, sb1_reg, sa2_reg, sb2_reg, sa3_reg, sb3_reg;
    logic [105:0] acc1_reg, acc2_reg, acc3_reg, acc4_reg, acc5_reg;
    logic [7:0]   lzp5_reg, lzc5_reg, lz9_reg;
    logic [127:0] xp6_reg, xc6_reg, xp7_reg, xc7_reg;
    exp_t         ep6_reg, ec6_reg, e7_reg, e8_reg, e9_reg, be10_reg, be11_reg;
    logic [127:0] x8_reg, x9_reg, xn10_reg, xn11_reg;
    logic         s8_reg, s9_reg, s10_reg, s11_reg;
    logic         z8_reg, z9_reg, z10_reg, z11_reg;
    logic [63:0]  res_reg;

    // operand classes for the special-case result
    logic nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c, sp_in;

    always_comb begin
        nan_a  = (in_a[62:52] == 11'h7FF) && (in_a[51:0] != 52'd0);
        nan_b  = (in_b[62:52] == 11'h7FF) && (in_b[51:0] != 52'd0);
        nan_c  = (in_c[62:52] == 11'h7FF) && (in_c[51:0] != 52'd0);
        inf_a  = in_a[62:0] == F64_POS_INF[62:0];
        inf_b  = in_b[62:0] == F64_POS_INF[62:0];
        inf_c  = in_c[62:0] == F64_POS_INF[62:0];
        zero_a = in_a[62:0] == 63'd0;
        zero_b = in_b[62:0] == 63'd0;
        zero_c = in_c[62:0] == 63'd0;
        sp_in  = in_a[63] ^ in_b[63];

        side_next.spec  = 1'b1;
        side_next.specv = F64_QNAN;
        if (nan_a || nan_b || nan_c) begin
            side_next.specv = F64_QNAN;
        end else if (inf_a || inf_b) begin
            if (zero_a || zero_b || (inf_c && (in_c[63] != sp_in))) begin
                side_next.specv = F64_QNAN;
            end else begin
                side_next.specv = {sp_in, F64_POS_INF[62:0]};
            end
        end else if (inf_c) begin
            side_next.specv = in_c;
        end else if (zero_a || zero_b) begin
            if (zero_c) begin
                side_next.specv = (sp_in == in_c[63]) ? {sp_in, 63'd0} : 64'd0;
            end else begin
                side_next.specv = in_c;
            end
        end else begin
            side_next.spec = 1'b0;
        end
        side_next.sp    = sp_in;
        side_next.sc    = in_c[63];
        side_next.czero = zero_c;
        side_next.ep    = exp_of(in_a) + exp_of(in_b);
        side_next.ec    = exp_of(in_c);
        side_next.sigc  = sig_of(in_c);
    end

    // partial products of the 53x53 significand multiply
    logic [53:0] p_ll, p_lh, p_hl;
    logic [51:0] p_hh;
    assign p_ll = sa0_reg[26:0] * sb0_reg[26:0];
    assign p_lh = sa1_reg[26:0] * sb1_reg[52:27];
    assign p_hl = sa2_reg[52:27] * sb2_reg[26:0];
    assign p_hh = sa3_reg[52:27] * sb3_reg[52:27];

    // align step
    exp_t         d7;
    logic [127:0] xp7_next, xc7_next;
    exp_t         e7_next;
    always_comb begin
        d7       = ep6_reg - ec6_reg;
        xp7_next = xp6_reg;
        xc7_next = xc6_reg;
        e7_next  = ep6_reg;
        if (side_reg[6].czero) begin
            xc7_next = 128'd0;
        end else if (d7 >= 14'sd0) begin
            xc7_next = sticky_shr(xc6_reg, (d7 >= 14'sd128) ? 8'd128 : d7[7:0]);
        end else begin
            xp7_next = sticky_shr(xp6_reg, (-d7 >= 14'sd128) ? 8'd128 : 8'(-d7));
            e7_next  = ec6_reg;
        end
    end

    // add or subtract magnitudes
    logic [127:0] x8_next;
    logic         s8_next, z8_next;
    always_comb begin
        z8_next = 1'b0;
        s8_next = side_reg[7].sp;
        if (side_reg[7].sp == side_reg[7].sc) begin
            x8_next = xp7_reg + xc7_reg;
        end else if (xp7_reg == xc7_reg) begin
            x8_next = 128'd0;
            z8_next = 1'b1;
        end else if (xp7_reg > xc7_reg) begin
            x8_next = xp7_reg - xc7_reg;
        end else begin
            x8_next = xc7_reg - xp7_reg;
            s8_next = side_reg[7].sc;
        end
    end

    // subnormal shift
    exp_t         sh11;
    logic [127:0] xn11_next;
    exp_t         be11_next;
    always_comb begin
        sh11      = 14'sd1 - be10_reg;
        xn11_next = xn10_reg;
        be11_next = be10_reg;
        if (be10_reg < 14'sd1) begin
            xn11_next = sticky_shr(xn10_reg, (sh11 >= 14'sd128) ? 8'd128 : sh11[7:0]);
            be11_next = 14'sd1;
        end
    end

    // round and pack
    logic [52:0] m12;
    logic        inc12;
    logic [53:0] mr12;
    exp_t        bem1;
    logic [63:0] bits12, res_next;
    always_comb begin
        m12    = xn11_reg[127:75];
        inc12  = xn11_reg[74] & ((|xn11_reg[73:0]) | m12[0]);
        mr12   = {1'b0, m12} + 54'(inc12);
        bem1   = be11_reg - 14'sd1;
        bits12 = (64'(bem1[11:0]) << 52) + 64'(mr12);
        if (side_reg[11].spec) begin
            res_next = side_reg[11].specv;
        end else if (z11_reg) begin
            res_next = 64'd0;
        end else if (be11_reg >= 14'sd2047 || bits12 >= F64_POS_INF) begin
            res_next = {s11_reg, F64_POS_INF[62:0]};
        end else begin
            res_next = {s11_reg, bits12[62:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[FMA_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        side_reg[0] <= side_next;
        for (int k = 1; k < FMA_STAGES; k++) begin
            side_reg[k] <= side_reg[k-1];
        end
        sa0_reg  <= sig_of(in_a);
        sb0_reg  <= sig_of(in_b);
        sa1_reg  <= sa0_reg;
        sb1_reg  <= sb0_reg;
        sa2_reg  <= sa1_reg;
        sb2_reg  <= sb1_reg;
        sa3_reg  <= sa2_reg;
        sb3_reg  <= sb2_reg;
        acc1_reg <= 106'(p_ll);
        acc2_reg <= acc1_reg + (106'(p_lh) << 27);
        acc3_reg <= acc2_reg + (106'(p_hl) << 27);
        acc4_reg <= acc3_reg + (106'(p_hh) << 54);
        // leading-zero counts of product and addend
        acc5_reg <= acc4_reg;
        lzp5_reg <= lzc128({22'd0, acc4_reg});
        lzc5_reg <= lzc128({75'd0, side_reg[4].sigc});
        // both terms brought to bit 125
        xp6_reg  <= {22'd0, acc5_reg} << (lzp5_reg - 8'd2);
        xc6_reg  <= {75'd0, side_reg[5].sigc} << (lzc5_reg - 8'd2);
        ep6_reg  <= side_reg[5].ep - exp_t'({6'd0, lzp5_reg}) + 14'sd2;
        ec6_reg  <= side_reg[5].ec - exp_t'({6'd0, lzc5_reg}) + 14'sd2;
        xp7_reg  <= xp7_next;
        xc7_reg  <= xc7_next;
        e7_reg   <= e7_next;
        x8_reg   <= x8_next;
        s8_reg   <= s8_next;
        z8_reg   <= z8_next;
        e8_reg   <= e7_reg;
        x9_reg   <= x8_reg;
        lz9_reg  <= lzc128(x8_reg);
        e9_reg   <= e8_reg;
        s9_reg   <= s8_reg;
        z9_reg   <= z8_reg;
        xn10_reg <= x9_reg << lz9_reg;
        be10_reg <= e9_reg + 14'sd1150 - exp_t'({6'd0, lz9_reg});
        s10_reg  <= s9_reg;
        z10_reg  <= z9_reg;
        xn11_reg <= xn11_next;
        be11_reg <= be11_next;
        s11_reg  <= s10_reg;
        z11_reg  <= z10_reg;
        res_reg  <= res_next;
    end

    assign out_valid = vld_reg[FMA_STAGES-1];
    assign out_res   = res_reg;

endmodule

// ----- rtl/core/dpf_merge.sv -----
// Merge sequencer: reduces the four lane sums as (l0+l1)+(l2+l3), then adds
// the pairs of a partial last beat one by one. Uses dpf_pkg and dpf_fma.
module dpf_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  dpf_pkg::merge_req_t req,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [63:0]         res_value
);
    import dpf_pkg::*;

    merge_state_t state_reg, state_next;
    merge_req_t   req_reg, req_next;
    logic [3:0]   step_reg, step_next;
    logic         issue_reg, issue_next;
    logic [63:0]  acc0_reg, acc0_next, acc1_reg, acc1_next;

    logic [63:0] op_a, op_b, op_c, fma_res;
    logic        fma_vld;
    logic [3:0]  last_step, tail_off;
    logic [1:0]  tail_idx;

    assign last_step = 4'd2 + {1'b0, req_reg.tail_cnt, 1'b0};
    assign tail_off  = step_reg - 4'd3;
    assign tail_idx  = tail_off[2:1];

    // operand select: two reduction adds, the final add, then mul/add pairs
    always_comb begin
        if (step_reg == 4'd0) begin
            op_a = req_reg.lane_sum[0];
            op_b = F64_ONE;
            op_c = req_reg.lane_sum[1];
        end else if (step_reg == 4'd1) begin
            op_a = req_reg.lane_sum[2];
            op_b = F64_ONE;
            op_c = req_reg.lane_sum[3];
        end else if (step_reg[0]) begin
            op_a = req_reg.tail_a[tail_idx];
            op_b = req_reg.tail_b[tail_idx];
            op_c = F64_NEG_ZERO;
        end else begin
            op_a = acc0_reg;
            op_b = F64_ONE;
            op_c = acc1_reg;
        end
    end

    dpf_fma u_fma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (issue_reg),
        .in_a      (op_a),
        .in_b      (op_b),
        .in_c      (op_c),
        .out_valid (fma_vld),
        .out_res   (fma_res)
    );

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        step_next  = step_reg;
        issue_next = 1'b0;
        acc0_next  = acc0_reg;
        acc1_next  = acc1_reg;
        case (state_reg)
            MRG_IDLE: begin
                if (start) begin
                    req_next   = req;
                    step_next  = 4'd0;
                    issue_next = 1'b1;
                    state_next = MRG_BUSY;
                end
            end
            MRG_BUSY: begin
                if (fma_vld) begin
                    if (step_reg[0]) begin
                        acc1_next = fma_res;
                    end else begin
                        acc0_next = fma_res;
                    end
                    if (step_reg == last_step) begin
                        state_next = MRG_HOLD;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        issue_next = 1'b1;
                    end
                end
            end
            MRG_HOLD: begin
                if (res_ready) begin
                    state_next = MRG_IDLE;
                end
            end
            default: begin
                state_next = MRG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MRG_IDLE;
            step_reg  <= 4'd0;
            issue_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        acc0_reg <= acc0_next;
        acc1_reg <= acc1_next;
    end

    assign idle      = state_reg == MRG_IDLE;
    assign res_valid = state_reg == MRG_HOLD;
    assign res_value = acc0_reg;

endmodule

// ----- rtl/core/dot_product_f64_four_lane.sv -----
// Four-lane binary64 dot product, top level. Each input beat carries four
// element pairs; every pair of a beat other than a partial last beat goes
// through its own 13-stage fused multiply-add into a lane accumulator, round
// to nearest even. The accumulator recurrence through that FMA holds the
// input: a beat that starts lanes holds s_ready low until its lane results
// are back; a non-last beat with no pairs leaves s_ready high. Once the
// beat with last_item set has left the lanes, the lane sums go to a merge
// sequencer that reduces (l0+l1)+(l2+l3) and, for a partial last beat, adds
// each pair as a rounded product and a rounded add; these 3 + 2*partial_pairs
// operations run one after another on one shared FMA. The lanes
// are cleared when the merge takes them, so the next vector streams in while
// the reduction runs; the result waits in an output register for m_ready.
// Depends on dpf_pkg, dpf_fma and dpf_merge.
module dot_product_f64_four_lane (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_a_lane0,
    input  logic [63:0] s_a_lane1,
    input  logic [63:0] s_a_lane2,
    input  logic [63:0] s_a_lane3,
    input  logic [63:0] s_b_lane0,
    input  logic [63:0] s_b_lane1,
    input  logic [63:0] s_b_lane2,
    input  logic [63:0] s_b_lane3,
    input  logic [2:0]  s_pair_count,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_dot_value
);
    import dpf_pkg::*;

    logic [LANES-1:0][63:0] a_vec, b_vec;
    logic [LANES-1:0][63:0] lane_sum_reg;
    logic [LANES-1:0][63:0] lane_res;
    logic [LANES-1:0]       lane_start, lane_vld;

    logic [TAILS-1:0][63:0] tail_a_reg, tail_b_reg;
    logic [1:0]             tail_cnt_reg;

    logic        busy_reg, pending_last_reg;
    logic        m_valid_reg;
    logic [63:0] m_dot_value_reg;

    logic        accept, run_lanes, merge_start, merge_idle;
    logic        res_valid, res_ready, res_take;
    logic [63:0] res_value;
    logic [2:0]  n_eff;
    merge_req_t  mreq;

    assign a_vec = {s_a_lane3, s_a_lane2, s_a_lane1, s_a_lane0};
    assign b_vec = {s_b_lane3, s_b_lane2, s_b_lane1, s_b_lane0};

    // counts above four count as four
    assign n_eff   = (s_pair_count > 3'd4) ? 3'd4 : s_pair_count;
    assign s_ready = !busy_reg && !pending_last_reg;
    assign accept  = s_valid && s_ready;

    // a partial last beat bypasses the lanes and goes to the merge tail
    assign run_lanes = accept && (!s_last_item || n_eff == 3'd4);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_start[i] = run_lanes && (3'(i) < n_eff);
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            dpf_fma u_fma (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (lane_start[g]),
                .in_a      (a_vec[g]),
                .in_b      (b_vec[g]),
                .in_c      (lane_sum_reg[g]),
                .out_valid (lane_vld[g]),
                .out_res   (lane_res[g])
            );
        end
    endgenerate

    // lanes wait for all started lanes; lane 0 always runs when any does
    assign merge_start = pending_last_reg && !busy_reg && merge_idle;

    assign mreq.lane_sum = lane_sum_reg;
    assign mreq.tail_a   = tail_a_reg;
    assign mreq.tail_b   = tail_b_reg;
    assign mreq.tail_cnt = tail_cnt_reg;

    dpf_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (merge_start),
        .req       (mreq),
        .idle      (merge_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign res_take  = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            pending_last_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            lane_sum_reg     <= '0;
        end else begin
            if (busy_reg) begin
                busy_reg <= !lane_vld[0];
            end else begin
                busy_reg <= |lane_start;
            end
            if (merge_start) begin
                pending_last_reg <= 1'b0;
            end else if (accept && s_last_item) begin
                pending_last_reg <= 1'b1;
            end
            if (res_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // accumulators return to +0 once the merge holds a copy
            for (int i = 0; i < LANES; i++) begin
                if (merge_start) begin
                    lane_sum_reg[i] <= 64'd0;
                end else if (lane_vld[i]) begin
                    lane_sum_reg[i] <= lane_res[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_item) begin
            tail_a_reg   <= a_vec[TAILS-1:0];
            tail_b_reg   <= b_vec[TAILS-1:0];
            tail_cnt_reg <= (n_eff == 3'd4) ? 2'd0 : n_eff[1:0];
        end
        if (res_take) begin
            m_dot_value_reg <= res_value;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dot_value = m_dot_value_reg;

    // lane results only come back for beats in flight
    a_lane_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (|lane_vld) |-> busy_reg)
        else $error("lane result with no beat in flight");

    // merge never sees lane sums that are still being updated
    a_merge_start: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_start |-> (!busy_reg && lane_vld == '0))
        else $error("merge started while lanes busy");

    // a beat that starts lanes or ends a vector closes the input
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_last_item || s_pair_count != 3'd0)) |=> !s_ready)
        else $error("input still open after a working beat");

    // output register loads only from a finished merge
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(res_valid))
        else $error("result with no merge behind it");

endmodule

// ----- test/testbench.sv -----
// Testbench for dot_product_f64_four_lane: random and directed vectors, checked
// against an in-bench binary64 dot-product predictor with exact FMA rounding.
// Depends on the RTL top level and dpf_pkg.
`timescale 1ns / 1ps

module testbench;
    import dpf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_a_lane0 = '0, s_a_lane1 = '0, s_a_lane2 = '0, s_a_lane3 = '0;
    logic [63:0] s_b_lane0 = '0, s_b_lane1 = '0, s_b_lane2 = '0, s_b_lane3 = '0;
    logic [2:0]  s_pair_count = '0;
    logic        s_last_item = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_dot_value;

    dot_product_f64_four_lane uut (.*);

    // predictor state and the queue of dot products still owed by the block
    logic [63:0] lane_acc [LANES];
    logic [63:0] dot_q [$];
    int          fail_count = 0;
    int          burst_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop if the block hangs
    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // binary64 arithmetic on integers, round to nearest even
    // ---------------------------------------------------------------------
    function automatic int msb128(input logic [127:0] x);
        int r;
        r = -1;
        for (int i = 0; i < 128; i++)
            if (x[i]) r = i;
        return r;
    endfunction

    // round sign * x * 2^e to binary64 (x nonzero)
    function automatic logic [63:0] round_to_f64(input bit sign, input logic [127:0] x,
                                                 input int e);
        int t, be, sh;
        logic [63:0]  m, bits;
        logic [127:0] q, rem, half;
        t  = msb128(x);
        be = t + e + 1023;
        sh = t - 52;
        if (be < 1) begin
            sh += 1 - be;
            be = 1;
        end
        if (sh <= 0) begin
            m = 64'(x << (-sh));
        end else if (sh > 128) begin
            m = '0;
        end else begin
            q    = (sh == 128) ? '0 : x >> sh;
            rem  = x - ((sh == 128) ? '0 : q << sh);
            half = 128'd1 << (sh - 1);
            m    = q[63:0];
            if (rem > half || (rem == half && m[0])) m++;
        end
        if (be >= 2047) return {sign, F64_POS_INF[62:0]};
        bits = (64'(be - 1) << 52) + m;
        if (bits >= F64_POS_INF) bits = F64_POS_INF;
        return {sign, bits[62:0]};
    endfunction

    function automatic bit f_nan(input logic [63:0] x);
        return x[62:52] == 11'h7FF && x[51:0] != 0;
    endfunction
    function automatic bit f_inf(input logic [63:0] x);
        return x[62:0] == F64_POS_INF[62:0];
    endfunction
    function automatic bit f_zero(input logic [63:0] x);
        return x[62:0] == 0;
    endfunction
    function automatic logic [52:0] f_sig(input logic [63:0] x);
        return {x[62:52] != 0, x[51:0]};
    endfunction
    function automatic int f_exp(input logic [63:0] x);
        return ((x[62:52] != 0) ? int'(x[62:52]) : 1) - 1075;
    endfunction

    function automatic logic [127:0] shr_sticky(input logic [127:0] x, input int n);
        logic [127:0] r;
        if (n == 0) return x;
        if (n >= 128) return {127'd0, x != 0};
        r = x >> n;
        if ((r << n) != x) r[0] = 1'b1;
        return r;
    endfunction

    // a*b + c, rounded once
    function automatic logic [63:0] fma64(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] c);
        bit sp, sc, s;
        logic [127:0] xp, xc, x;
        int ep, ec, e, sh;
        sp = a[63] ^ b[63];
        sc = c[63];
        if (f_nan(a) || f_nan(b) || f_nan(c)) return F64_QNAN;
        if (f_inf(a) || f_inf(b)) begin
            if (f_zero(a) || f_zero(b)) return F64_QNAN;
            if (f_inf(c) && sc != sp) return F64_QNAN;
            return {sp, F64_POS_INF[62:0]};
        end
        if (f_inf(c)) return c;
        if (f_zero(a) || f_zero(b)) begin
            if (f_zero(c)) return (sp == sc) ? {sp, 63'd0} : 64'd0;
            return c;
        end
        xp = 128'(f_sig(a)) * 128'(f_sig(b));
        ep = f_exp(a) + f_exp(b);
        if (f_zero(c)) return round_to_f64(sp, xp, ep);
        sh = 125 - msb128(xp);
        xp = xp << sh;
        ep -= sh;
        xc = 128'(f_sig(c));
        ec = f_exp(c);
        sh = 125 - msb128(xc);
        xc = xc << sh;
        ec -= sh;
        if (ep >= ec) begin
            xc = shr_sticky(xc, ep - ec);
            e  = ep;
        end else begin
            xp = shr_sticky(xp, ec - ep);
            e  = ec;
        end
        if (sp == sc) begin
            x = xp + xc;
            s = sp;
        end else begin
            if (xp == xc) return 64'd0;   // exact cancellation gives +0
            if (xp > xc) begin
                x = xp - xc;
                s = sp;
            end else begin
                x = xc - xp;
                s = sc;
            end
        end
        return round_to_f64(s, x, e);
    endfunction

    function automatic logic [63:0] add64(input logic [63:0] x, input logic [63:0] y);
        return fma64(x, F64_ONE, y);
    endfunction

    // advance the lane sums by one accepted beat; queue a dot product on last
    task automatic predict_beat(input logic [3:0][63:0] a, input logic [3:0][63:0] b,
                                input logic [2:0] cnt, input bit last);
        int n;
        logic [63:0] dot;
        n = (cnt > LANES) ? LANES : int'(cnt);
        if (!last || n == LANES)
            for (int i = 0; i < n; i++) lane_acc[i] = fma64(a[i], b[i], lane_acc[i]);
        if (last) begin
            dot = add64(add64(lane_acc[0], lane_acc[1]), add64(lane_acc[2], lane_acc[3]));
            if (n < LANES)
                for (int i = 0; i < n; i++)
                    dot = add64(dot, fma64(a[i], b[i], F64_NEG_ZERO));
            dot_q.push_back(dot);
            for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    function automatic logic [63:0] rand_f64();
        logic [63:0] v;
        bit sg;
        sg = $urandom_range(0, 1);
        v  = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: return 64'd0;
            1: return F64_NEG_ZERO;
            2: return {sg, F64_POS_INF[62:0]};
            3: begin
                v[51 - $urandom_range(0, 51)] = 1'b1;
                return {sg, 11'h7FF, v[51:0]};
            end
            4: return {sg, 11'd0, v[51:0]};
            5: return {sg, 11'($urandom_range(2040, 2046)), v[51:0]};
            6, 7: return v;
            default: return {sg, 11'($urandom_range(1013, 1033)), v[51:0]};
        endcase
    endfunction

    // one input beat; valid stays up across a burst, drops for a random gap after
    task automatic send_beat(input logic [3:0][63:0] a, input logic [3:0][63:0] b,
                             input logic [2:0] cnt, input bit last);
        s_valid      <= 1'b1;
        s_a_lane0    <= a[0];
        s_a_lane1    <= a[1];
        s_a_lane2    <= a[2];
        s_a_lane3    <= a[3];
        s_b_lane0    <= b[0];
        s_b_lane1    <= b[1];
        s_b_lane2    <= b[2];
        s_b_lane3    <= b[3];
        s_pair_count <= cnt;
        s_last_item  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(a, b, cnt, last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // one beat with all four lanes set to the same pair
    task automatic send_pair(input logic [63:0] x, input logic [63:0] y,
                             input logic [2:0] cnt, input bit last);
        send_beat({4{x}}, {4{y}}, cnt, last);
    endtask

    task automatic test_directed();
        logic [63:0] one_n, huge;
        one_n = {1'b1, F64_ONE[62:0]};
        huge  = 64'h7FEF_FFFF_FFFF_FFFF;
        send_pair('0, '0, 3'd0, 1'b1);                       // empty vector
        send_pair(F64_ONE, F64_ONE, 3'd1, 1'b1);              // one partial pair
        send_pair(F64_ONE, F64_ONE, 3'd4, 1'b1);              // full last beat
        send_pair(F64_POS_INF, '0, 3'd4, 1'b1);               // inf * 0
        send_pair(F64_POS_INF, F64_ONE, 3'd4, 1'b0);          // inf - inf across lanes
        send_beat({F64_ONE, F64_ONE, one_n, F64_ONE},
                  {F64_POS_INF, F64_POS_INF, F64_POS_INF, F64_POS_INF}, 3'd4, 1'b1);
        send_pair(64'h7FF0_0000_0000_0001, F64_ONE, 3'd2, 1'b1); // NaN operand
        send_pair(huge, huge, 3'd4, 1'b1);                    // overflow
        send_pair(huge, F64_ONE, 3'd4, 1'b0);                 // overflow in reduction
        send_pair(huge, F64_ONE, 3'd3, 1'b1);
        send_pair(F64_ONE, F64_ONE, 3'd4, 1'b0);              // exact cancellation
        send_pair(one_n, F64_ONE, 3'd4, 1'b1);
        send_pair(F64_NEG_ZERO, F64_ONE, 3'd4, 1'b1);          // signed zeros
        send_pair(64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 3'd4, 1'b1); // subnormal
        send_pair(64'h000F_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 3'd3, 1'b1);
        send_pair(F64_ONE, 64'hC000_0000_0000_0000, 3'd7, 1'b0); // count above four
        send_pair(F64_ONE, F64_ONE, 3'd5, 1'b1);
        send_pair(F64_ONE, F64_ONE, 3'd2, 1'b0);              // partial beat, not last
        send_pair(F64_ONE, F64_ONE, 3'd0, 1'b0);              // no pairs, not last
        send_pair(F64_ONE, F64_ONE, 3'd6, 1'b1);
    endtask

    // well-formed vectors: full beats then a last beat of 0..4 pairs
    task automatic test_random_vectors(input int beats);
        logic [3:0][63:0] a, b;
        int sent, len;
        sent = 0;
        while (sent < beats) begin
            len = $urandom_range(0, 6);
            for (int k = 0; k <= len; k++) begin
                for (int i = 0; i < LANES; i++) begin
                    a[i] = rand_f64();
                    b[i] = rand_f64();
                end
                if (k < len) send_beat(a, b, 3'd4, 1'b0);
                else send_beat(a, b, 3'($urandom_range(0, 4)), 1'b1);
                sent++;
            end
        end
    endtask

    // malformed traffic: counts above four, partial middle beats, full random bits
    task automatic test_noise(input int beats);
        logic [3:0][63:0] a, b;
        for (int k = 0; k < beats; k++) begin
            for (int i = 0; i < LANES; i++) begin
                a[i] = {$urandom, $urandom};
                b[i] = rand_f64();
            end
            send_beat(a, b, 3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0));
        end
    endtask

    // receiver stall pattern: phases of always-ready, coin-flip and long stalls
    int rx_phase = 0;
    int rx_count = 0;
    always @(posedge aclk) begin
        if (rx_count == 0) begin
            rx_phase <= $urandom_range(0, 2);
            rx_count <= $urandom_range(20, 200);
        end else begin
            rx_count <= rx_count - 1;
        end
        case (rx_phase)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // result checker: every accepted beat against the oldest owed dot product
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (dot_q.size() == 0) begin
                $error("unexpected result beat: dot_value actual %h", m_dot_value);
                fail_count++;
            end else begin
                if (m_dot_value !== dot_q[0]) begin
                    $error("dot_value mismatch: expected %h actual %h",
                           dot_q[0], m_dot_value);
                    fail_count++;
                end
                void'(dot_q.pop_front());
            end
        end
    end

    initial begin
        for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_vectors(950);
        test_noise(120);
        test_random_vectors(60);
        s_valid <= 1'b0;
        while (dot_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && dot_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
